// ===== rtl/kcpsm_pkg.sv =====
// Shared types, opcode constants and sizes for the 8-bit controller execute block.
package kcpsm_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  // Instruction groups, taken from bits 15:12.
  localparam logic [3:0] OP_CTRL  = 4'h8;
  localparam logic [3:0] OP_COND  = 4'h9;
  localparam logic [3:0] OP_IN_K  = 4'hA;
  localparam logic [3:0] OP_IN_R  = 4'hB;
  localparam logic [3:0] OP_ALU_R = 4'hC;
  localparam logic [3:0] OP_SHIFT = 4'hD;
  localparam logic [3:0] OP_OUT_K = 4'hE;
  localparam logic [3:0] OP_OUT_R = 4'hF;

  // Fixed control words.
  localparam logic [15:0] INS_EINT     = 16'h8030;
  localparam logic [15:0] INS_DINT     = 16'h8010;
  localparam logic [15:0] INS_RETI_DIS = 16'h80D0;
  localparam logic [15:0] INS_RETI_EN  = 16'h80F0;
  localparam logic [7:0]  RET_LOW      = 8'h80;

  // ALU operations.
  localparam logic [2:0] ALU_LOAD  = 3'd0;
  localparam logic [2:0] ALU_AND   = 3'd1;
  localparam logic [2:0] ALU_OR    = 3'd2;
  localparam logic [2:0] ALU_XOR   = 3'd3;
  localparam logic [2:0] ALU_ADD   = 3'd4;
  localparam logic [2:0] ALU_ADDCY = 3'd5;
  localparam logic [2:0] ALU_SUB   = 3'd6;
  localparam logic [2:0] ALU_SUBCY = 3'd7;

  // Shift and rotate codes.
  localparam logic [3:0] SH_SLA = 4'h0;
  localparam logic [3:0] SH_RL  = 4'h2;
  localparam logic [3:0] SH_SLX = 4'h4;
  localparam logic [3:0] SH_SL0 = 4'h6;
  localparam logic [3:0] SH_SL1 = 4'h7;
  localparam logic [3:0] SH_SRA = 4'h8;
  localparam logic [3:0] SH_SRX = 4'hA;
  localparam logic [3:0] SH_RR  = 4'hC;
  localparam logic [3:0] SH_SR0 = 4'hE;
  localparam logic [3:0] SH_SR1 = 4'hF;

  // Conditional flow forms, bits 9:8.
  localparam logic [1:0] CF_RETURN = 2'd0;
  localparam logic [1:0] CF_JUMP   = 2'd1;
  localparam logic [1:0] CF_BAD    = 2'd2;
  localparam logic [1:0] CF_CALL   = 2'd3;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_RETURN = 2'd2;

  localparam logic [4:0] DEPTH_MAX = 5'd31;

  typedef struct packed {
    logic       rf_we;
    logic [7:0] rf_wdata;
    logic       push;
    logic       pop;
    logic [7:0] push_data;
    logic [7:0] pc_next;
    logic       carry;
    logic       zero;
    logic       ie;
    logic [4:0] depth_next;
    logic [7:0] port_id;
    logic [7:0] out_data;
    logic       read_strobe;
    logic       write_strobe;
    logic [1:0] fault;
  } exec_t;

endpackage

// ===== rtl/kcpsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kcpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kcpsm_exec.sv =====
// Combinational execute logic: decode, ALU, shifter, flow control and port strobes.
module kcpsm_exec (
  input  logic [15:0]          ins,
  input  logic [7:0]           pin,
  input  logic [7:0]           pc,
  input  logic                 carry,
  input  logic                 zero,
  input  logic                 ie,
  input  logic [4:0]           depth,
  input  logic [7:0]           rx,
  input  logic [7:0]           ry,
  input  logic [7:0]           st_top,
  output kcpsm_pkg::exec_t     e
);

  always_comb begin
    logic [7:0] pc1;
    logic [7:0] k;
    logic [7:0] alu_b;
    logic [2:0] aop;
    logic [8:0] sum;
    logic [7:0] sh_r;
    logic       sh_c;
    logic       sh_ok;
    logic       cond;
    logic       do_ret;
    logic       do_call;

    pc1     = pc + 8'd1;
    k       = ins[7:0];
    do_ret  = 1'b0;
    do_call = 1'b0;
    sh_r    = 8'h00;
    sh_c    = 1'b0;
    sh_ok   = 1'b1;

    e              = '0;
    e.pc_next      = pc1;
    e.push_data    = pc1;
    e.carry        = carry;
    e.zero         = zero;
    e.ie           = ie;
    e.depth_next   = depth;
    e.fault        = kcpsm_pkg::FAULT_NONE;

    // ALU: register operand group takes its operation from the low bits.
    aop   = (ins[15:12] == kcpsm_pkg::OP_ALU_R) ? ins[2:0] : ins[14:12];
    alu_b = (ins[15:12] == kcpsm_pkg::OP_ALU_R) ? ry : k;
    case (aop)
      kcpsm_pkg::ALU_LOAD:  sum = {1'b0, alu_b};
      kcpsm_pkg::ALU_AND:   sum = {1'b0, rx & alu_b};
      kcpsm_pkg::ALU_OR:    sum = {1'b0, rx | alu_b};
      kcpsm_pkg::ALU_XOR:   sum = {1'b0, rx ^ alu_b};
      kcpsm_pkg::ALU_ADD:   sum = {1'b0, rx} + {1'b0, alu_b};
      kcpsm_pkg::ALU_ADDCY: sum = {1'b0, rx} + {1'b0, alu_b} + {8'd0, carry};
      kcpsm_pkg::ALU_SUB:   sum = {1'b0, rx} - {1'b0, alu_b};
      default:              sum = {1'b0, rx} - {1'b0, alu_b} - {8'd0, carry};
    endcase

    case (ins[3:0])
      kcpsm_pkg::SH_SLA: begin sh_r = {rx[6:0], carry};  sh_c = rx[7]; end
      kcpsm_pkg::SH_RL:  begin sh_r = {rx[6:0], rx[7]};  sh_c = rx[7]; end
      kcpsm_pkg::SH_SLX: begin sh_r = {rx[6:0], rx[0]};  sh_c = rx[7]; end
      kcpsm_pkg::SH_SL0: begin sh_r = {rx[6:0], 1'b0};   sh_c = rx[7]; end
      kcpsm_pkg::SH_SL1: begin sh_r = {rx[6:0], 1'b1};   sh_c = rx[7]; end
      kcpsm_pkg::SH_SRA: begin sh_r = {carry, rx[7:1]};  sh_c = rx[0]; end
      kcpsm_pkg::SH_SRX: begin sh_r = {rx[7], rx[7:1]};  sh_c = rx[0]; end
      kcpsm_pkg::SH_RR:  begin sh_r = {rx[0], rx[7:1]};  sh_c = rx[0]; end
      kcpsm_pkg::SH_SR0: begin sh_r = {1'b0, rx[7:1]};   sh_c = rx[0]; end
      kcpsm_pkg::SH_SR1: begin sh_r = {1'b1, rx[7:1]};   sh_c = rx[0]; end
      default:           sh_ok = 1'b0;
    endcase

    cond = (ins[11] ? carry : zero) ^ ins[10];

    case (ins[15:12])
      kcpsm_pkg::OP_CTRL: begin
        if (ins == kcpsm_pkg::INS_EINT) begin
          e.ie = 1'b1;
        end else if (ins == kcpsm_pkg::INS_DINT) begin
          e.ie = 1'b0;
        end else if (ins == kcpsm_pkg::INS_RETI_DIS || ins == kcpsm_pkg::INS_RETI_EN) begin
          // Return from interrupt pops the stack but leaves the call depth alone.
          e.ie      = (ins == kcpsm_pkg::INS_RETI_EN);
          e.pop     = 1'b1;
          e.pc_next = st_top;
        end else if (ins[9]) begin
          do_call = ins[8];
        end else if (ins[8]) begin
          e.pc_next = k;
        end else if (k == kcpsm_pkg::RET_LOW) begin
          do_ret = 1'b1;
        end
      end
      kcpsm_pkg::OP_COND: begin
        case (ins[9:8])
          kcpsm_pkg::CF_RETURN: begin
            if (k == kcpsm_pkg::RET_LOW) begin
              do_ret = cond;
            end else begin
              e.fault = kcpsm_pkg::FAULT_OPCODE;
            end
          end
          kcpsm_pkg::CF_JUMP: begin
            if (cond) begin
              e.pc_next = k;
            end
          end
          kcpsm_pkg::CF_BAD: e.fault = kcpsm_pkg::FAULT_OPCODE;
          default:           do_call = cond;
        endcase
      end
      kcpsm_pkg::OP_IN_K, kcpsm_pkg::OP_IN_R: begin
        e.port_id     = (ins[15:12] == kcpsm_pkg::OP_IN_K) ? k : ry;
        e.read_strobe = 1'b1;
        e.rf_we       = 1'b1;
        e.rf_wdata    = pin;
      end
      kcpsm_pkg::OP_SHIFT: begin
        if (sh_ok) begin
          e.rf_we    = 1'b1;
          e.rf_wdata = sh_r;
          e.carry    = sh_c;
          e.zero     = (sh_r == 8'h00);
        end else begin
          e.fault = kcpsm_pkg::FAULT_OPCODE;
        end
      end
      kcpsm_pkg::OP_OUT_K, kcpsm_pkg::OP_OUT_R: begin
        e.port_id      = (ins[15:12] == kcpsm_pkg::OP_OUT_K) ? k : ry;
        e.out_data     = rx;
        e.write_strobe = 1'b1;
      end
      default: begin
        // Constant-operand ALU group and the register-operand ALU group.
        e.rf_we    = 1'b1;
        e.rf_wdata = sum[7:0];
        if (aop != kcpsm_pkg::ALU_LOAD) begin
          e.carry = sum[8];
          e.zero  = (sum[7:0] == 8'h00);
        end
      end
    endcase

    if (do_call) begin
      e.push       = 1'b1;
      e.pc_next    = k;
      e.depth_next = (depth == kcpsm_pkg::DEPTH_MAX) ? depth : depth + 5'd1;
    end
    if (do_ret) begin
      e.pop        = 1'b1;
      e.pc_next    = st_top;
      e.fault      = (depth == 5'd0) ? kcpsm_pkg::FAULT_RETURN : kcpsm_pkg::FAULT_NONE;
      e.depth_next = (depth == 5'd0) ? depth : depth - 5'd1;
    end
  end

endmodule

// ===== rtl/kcpsm_8bit_instruction_execute.sv =====
// Top level of the 8-bit controller execute block: pipeline, state and storage.
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// 16-bit instruction word and the byte on the input port. Each instruction
// yields exactly one result transfer on the output channel (out_valid/out_ready)
// holding the next fetch address, port activity, flags and a fault code.
// The transfer edge loads the instruction register and launches the
// register-file and return stack reads (both registered-read RAMs), and the
// instruction then executes into the result register once the result
// register is free to take it. Throughput is one instruction per cycle while
// the receiver does not stall; the register-file and stack reads for the next
// instruction are forwarded from the write of the one executing, so dependent
// instructions run back to back.
// Reset clears the program counter, flags, stack pointer, call depth and the
// valid bits that make every register and stack entry read as zero until
// written; no clearing pass is needed. When the receiver stalls, the result
// register holds and the instruction in the input register waits; in_ready
// drops only when both are full.
module kcpsm_8bit_instruction_execute #(
  parameter int STACK_DEPTH = kcpsm_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] instruction,
  input  logic [7:0]  in_port_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  next_pc,
  output logic [7:0]  port_id,
  output logic [7:0]  out_data,
  output logic        read_strobe,
  output logic        write_strobe,
  output logic        carry_out,
  output logic        zero_out,
  output logic        int_enable_out,
  output logic [1:0]  fault
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

  logic        in_xfer;
  logic        advance;
  logic        s1_valid;
  logic [15:0] s1_ins;
  logic [7:0]  s1_pin;

  logic [7:0]  pc;
  logic        carry;
  logic        zero;
  logic        ie;
  logic [4:0]  depth;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_inc;
  logic [SPW-1:0] sp_dec;
  logic [SPW-1:0] sp_next;
  logic [SPW-1:0] st_base;
  logic [SPW-1:0] st_raddr;

  kcpsm_pkg::exec_t e;

  // Register file: two read copies written together.
  logic [3:0]  rd_x;
  logic [3:0]  rd_y;
  logic        rf_we;
  logic [3:0]  rf_waddr;
  logic [15:0] rf_valid;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic        x_fwd;
  logic        y_fwd;
  logic        x_vld;
  logic        y_vld;
  logic [7:0]  rf_fwd_data;
  logic [7:0]  rx;
  logic [7:0]  ry;

  // Return stack.
  logic                   st_we;
  logic [STACK_DEPTH-1:0] st_valid;
  logic [7:0]             st_q;
  logic                   st_fwd;
  logic                   st_vld;
  logic [7:0]             st_fwd_data;
  logic [7:0]             st_top;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_xfer) begin
      s1_ins <= instruction;
      s1_pin <= in_port_data;
    end
  end

  // Reads are issued for whichever instruction occupies the input register next cycle.
  assign rd_x     = in_xfer ? instruction[11:8] : s1_ins[11:8];
  assign rd_y     = in_xfer ? instruction[7:4]  : s1_ins[7:4];
  assign rf_we    = advance && e.rf_we;
  assign rf_waddr = s1_ins[11:8];

  kcpsm_ram #(.WIDTH(8), .DEPTH(16)) u_rf_x (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(e.rf_wdata),
    .raddr(rd_x), .rdata(x_q)
  );

  kcpsm_ram #(.WIDTH(8), .DEPTH(16)) u_rf_y (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(e.rf_wdata),
    .raddr(rd_y), .rdata(y_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_waddr] <= 1'b1;
    end
    x_fwd       <= rf_we && (rf_waddr == rd_x);
    y_fwd       <= rf_we && (rf_waddr == rd_y);
    x_vld       <= rf_valid[rd_x];
    y_vld       <= rf_valid[rd_y];
    rf_fwd_data <= e.rf_wdata;
  end

  assign rx = x_fwd ? rf_fwd_data : (x_vld ? x_q : 8'h00);
  assign ry = y_fwd ? rf_fwd_data : (y_vld ? y_q : 8'h00);

  // Circular stack pointer arithmetic.
  assign sp_inc  = (sp == SP_LAST) ? '0 : sp + SPW'(1);
  assign sp_dec  = (sp == '0) ? SP_LAST : sp - SPW'(1);
  assign sp_next = e.push ? sp_inc : (e.pop ? sp_dec : sp);
  assign st_base = advance ? sp_next : sp;
  assign st_raddr = (st_base == '0) ? SP_LAST : st_base - SPW'(1);
  assign st_we    = advance && e.push;

  kcpsm_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(sp), .wdata(e.push_data),
    .raddr(st_raddr), .rdata(st_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (st_we) begin
      st_valid[sp] <= 1'b1;
    end
    st_fwd      <= st_we && (sp == st_raddr);
    st_vld      <= st_valid[st_raddr];
    st_fwd_data <= e.push_data;
  end

  assign st_top = st_fwd ? st_fwd_data : (st_vld ? st_q : 8'h00);

  kcpsm_exec u_exec (
    .ins(s1_ins), .pin(s1_pin), .pc(pc), .carry(carry), .zero(zero), .ie(ie),
    .depth(depth), .rx(rx), .ry(ry), .st_top(st_top), .e(e)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= 8'h00;
      carry <= 1'b0;
      zero  <= 1'b0;
      ie    <= 1'b0;
      depth <= 5'd0;
      sp    <= '0;
    end else if (advance) begin
      pc    <= e.pc_next;
      carry <= e.carry;
      zero  <= e.zero;
      ie    <= e.ie;
      depth <= e.depth_next;
      sp    <= sp_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      next_pc        <= e.pc_next;
      port_id        <= e.port_id;
      out_data       <= e.out_data;
      read_strobe    <= e.read_strobe;
      write_strobe   <= e.write_strobe;
      carry_out      <= e.carry;
      zero_out       <= e.zero;
      int_enable_out <= e.ie;
      fault          <= e.fault;
    end
  end

  // The decode is only meaningful while the input register holds an instruction.
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(e.push && e.pop))
    else $error("push and pop requested together");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_ins))
    else $error("stalled instruction lost from input register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && next_pc == pc)
    else $error("result register and program counter disagree");

  a_strobes_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_strobe && write_strobe) && fault != 2'd3)
    else $error("inconsistent port strobes or fault code");

  a_push_steps: assert property (@(posedge clk) disable iff (rst)
    advance && e.push |=> sp == $past(sp_inc))
    else $error("stack pointer did not step on call");

endmodule

// ===== bench/tb_kcpsm_8bit_instruction_execute.sv =====
// Self-checking testbench for the 8-bit controller instruction execute block.
module tb_kcpsm_8bit_instruction_execute;
  import kcpsm_pkg::*;

  localparam int N_RANDOM    = 1350;
  localparam int N_TABLE     = 29;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_EVERY = 400;
  localparam int MAX_PRINTS  = 50;

  // One retired instruction as seen on the result channel.
  typedef struct packed {
    logic [7:0] pc;
    logic [7:0] port;
    logic [7:0] data;
    logic       rd;
    logic       wr;
    logic       c;
    logic       z;
    logic       ie;
    logic [1:0] flt;
  } retire_t;

  typedef struct packed {
    logic [15:0] ins;
    logic [7:0]  pin;
    logic        fixed;
    logic [7:0]  pc;
    logic [1:0]  flt;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] instruction = '0;
  logic [7:0]  in_port_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  next_pc;
  logic [7:0]  port_id;
  logic [7:0]  out_data;
  logic        read_strobe;
  logic        write_strobe;
  logic        carry_out;
  logic        zero_out;
  logic        int_enable_out;
  logic [1:0]  fault;

  // Hand-typed next address and fault that travel with a table row.
  logic        tag_fixed = 1'b0;
  logic [7:0]  tag_pc = '0;
  logic [1:0]  tag_fault = FAULT_NONE;

  // Shadow copy of the architectural state.
  logic [7:0]  shadow_reg [16];
  logic [7:0]  shadow_stack [STACK_DEPTH_DEF];
  logic [7:0]  shadow_pc;
  logic        shadow_c;
  logic        shadow_z;
  logic        shadow_ie;
  int unsigned shadow_sp;
  logic [4:0]  shadow_depth;

  retire_t     pending_retire [$];
  int          n_errors = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_fault_op = 0;
  int          n_fault_ret = 0;
  int          n_port = 0;
  int          deepest = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic        sending = 1'b0;
  logic [1:0]  rx_mode = 2'd0;
  int          rx_phase = 0;

  kcpsm_8bit_instruction_execute dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= MAX_PRINTS) begin
      $display("[%0t] result %0d: %s got %0h, want %0h", $time, n_checked, what, got, want);
    end
  endtask

  function automatic logic [7:0] pop_return();
    shadow_sp = (shadow_sp + STACK_DEPTH_DEF - 1) % STACK_DEPTH_DEF;
    return shadow_stack[shadow_sp];
  endfunction

  function automatic void take_call(input logic [7:0] target);
    shadow_stack[shadow_sp] = shadow_pc;
    shadow_sp = (shadow_sp + 1) % STACK_DEPTH_DEF;
    shadow_pc = target;
    if (shadow_depth != DEPTH_MAX) shadow_depth = shadow_depth + 5'd1;
  endfunction

  // The stack is popped even when the call depth is already zero.
  function automatic logic [1:0] take_return();
    logic [1:0] flt;
    if (shadow_depth == 5'd0) begin
      flt = FAULT_RETURN;
    end else begin
      flt = FAULT_NONE;
      shadow_depth = shadow_depth - 5'd1;
    end
    shadow_pc = pop_return();
    return flt;
  endfunction

  function automatic void alu_exec(input logic [2:0] op, input logic [3:0] x,
                                   input logic [7:0] b);
    logic [8:0] sum;
    if (op == ALU_LOAD) begin
      shadow_reg[x] = b;
    end else begin
      case (op)
        ALU_AND:   sum = {1'b0, shadow_reg[x] & b};
        ALU_OR:    sum = {1'b0, shadow_reg[x] | b};
        ALU_XOR:   sum = {1'b0, shadow_reg[x] ^ b};
        ALU_ADD:   sum = {1'b0, shadow_reg[x]} + {1'b0, b};
        ALU_ADDCY: sum = {1'b0, shadow_reg[x]} + {1'b0, b} + {8'd0, shadow_c};
        ALU_SUB:   sum = {1'b0, shadow_reg[x]} - {1'b0, b};
        default:   sum = {1'b0, shadow_reg[x]} - {1'b0, b} - {8'd0, shadow_c};
      endcase
      // Bit 8 is the carry for additions and the borrow for subtractions.
      shadow_c = sum[8];
      shadow_z = (sum[7:0] == 8'd0);
      shadow_reg[x] = sum[7:0];
    end
  endfunction

  function automatic logic shift_exec(input logic [3:0] code, input logic [3:0] x);
    logic [7:0] v;
    logic [7:0] r;
    logic       c;
    logic       ok;
    v = shadow_reg[x];
    r = v;
    c = v[7];
    ok = 1'b1;
    case (code)
      SH_SLA: r = {v[6:0], shadow_c};
      SH_RL:  r = {v[6:0], v[7]};
      SH_SLX: r = {v[6:0], v[0]};
      SH_SL0: r = {v[6:0], 1'b0};
      SH_SL1: r = {v[6:0], 1'b1};
      SH_SRA: begin r = {shadow_c, v[7:1]}; c = v[0]; end
      SH_SRX: begin r = {v[7], v[7:1]}; c = v[0]; end
      SH_RR:  begin r = {v[0], v[7:1]}; c = v[0]; end
      SH_SR0: begin r = {1'b0, v[7:1]}; c = v[0]; end
      SH_SR1: begin r = {1'b1, v[7:1]}; c = v[0]; end
      default: ok = 1'b0;
    endcase
    if (ok) begin
      shadow_c = c;
      shadow_z = (r == 8'd0);
      shadow_reg[x] = r;
    end
    return ok;
  endfunction

  function automatic retire_t execute_instr(input logic [15:0] ins, input logic [7:0] pin);
    retire_t    res;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] k;
    logic       cond;
    x = ins[11:8];
    y = ins[7:4];
    k = ins[7:0];
    res = '0;
    res.flt = FAULT_NONE;
    shadow_pc = shadow_pc + 8'd1;
    case (ins[15:12])
      OP_CTRL: begin
        if (ins == INS_EINT) begin
          shadow_ie = 1'b1;
        end else if (ins == INS_DINT) begin
          shadow_ie = 1'b0;
        end else if (ins == INS_RETI_DIS || ins == INS_RETI_EN) begin
          shadow_ie = (ins == INS_RETI_EN);
          shadow_pc = pop_return();
        end else if (ins[9]) begin
          if (ins[8]) take_call(k);
        end else if (ins[8]) begin
          shadow_pc = k;
        end else if (k == RET_LOW) begin
          res.flt = take_return();
        end
      end
      OP_COND: begin
        cond = ins[11] ? shadow_c : shadow_z;
        if (ins[10]) cond = !cond;
        case (ins[9:8])
          CF_RETURN: begin
            if (k != RET_LOW) res.flt = FAULT_OPCODE;
            else if (cond) res.flt = take_return();
          end
          CF_JUMP: if (cond) shadow_pc = k;
          CF_BAD:  res.flt = FAULT_OPCODE;
          default: if (cond) take_call(k);
        endcase
      end
      OP_IN_K: begin
        res.port = k;
        res.rd = 1'b1;
        shadow_reg[x] = pin;
      end
      OP_IN_R: begin
        res.port = shadow_reg[y];
        res.rd = 1'b1;
        shadow_reg[x] = pin;
      end
      OP_ALU_R: alu_exec(ins[2:0], x, shadow_reg[y]);
      OP_SHIFT: if (!shift_exec(ins[3:0], x)) res.flt = FAULT_OPCODE;
      OP_OUT_K: begin
        res.port = k;
        res.data = shadow_reg[x];
        res.wr = 1'b1;
      end
      OP_OUT_R: begin
        res.port = shadow_reg[y];
        res.data = shadow_reg[x];
        res.wr = 1'b1;
      end
      default: alu_exec(ins[14:12], x, k);
    endcase
    res.pc = shadow_pc;
    res.c = shadow_c;
    res.z = shadow_z;
    res.ie = shadow_ie;
    return res;
  endfunction

  function automatic logic [15:0] random_instr();
    logic [7:0] k;
    logic [1:0] form;
    int         pick;
    case ($urandom_range(0, 7))
      0: k = 8'h00;
      1: k = 8'hFF;
      2: k = 8'h80;
      3: k = 8'h7F;
      default: k = 8'($urandom_range(0, 255));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) return {1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), k};
    if (pick < 45) return {OP_ALU_R, 12'($urandom_range(0, 4095))};
    if (pick < 57) return {OP_SHIFT, 12'($urandom_range(0, 4095))};
    if (pick < 67) begin
      case ($urandom_range(0, 3))
        0: return {OP_IN_K, 4'($urandom_range(0, 15)), k};
        1: return {OP_IN_R, 12'($urandom_range(0, 4095))};
        2: return {OP_OUT_K, 4'($urandom_range(0, 15)), k};
        default: return {OP_OUT_R, 12'($urandom_range(0, 4095))};
      endcase
    end
    if (pick < 78) begin
      case ($urandom_range(0, 7))
        0: return INS_EINT;
        1: return INS_DINT;
        2: return INS_RETI_DIS;
        3: return INS_RETI_EN;
        4: return {OP_CTRL, 2'($urandom_range(0, 3)), 2'b11, k};
        5: return {OP_CTRL, 2'($urandom_range(0, 3)), 2'b01, k};
        6: return {OP_CTRL, 2'($urandom_range(0, 3)), 2'b00, RET_LOW};
        default: return {OP_CTRL, 12'($urandom_range(0, 4095))};
      endcase
    end
    if (pick < 92) begin
      form = 2'($urandom_range(0, 3));
      return {OP_COND, 2'($urandom_range(0, 3)), form,
              (form == CF_RETURN && $urandom_range(0, 3) != 0) ? RET_LOW : k};
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offers one instruction and returns at the edge of its transfer, or after the random idle gap that ends a burst.
  task automatic issue(input logic [15:0] ins, input logic [7:0] pin,
                       input logic fixed = 1'b0, input logic [7:0] fpc = 8'h00,
                       input logic [1:0] fflt = FAULT_NONE);
    instruction  <= ins;
    in_port_data <= pin;
    tag_fixed    <= fixed;
    tag_pc       <= fpc;
    tag_fault    <= fflt;
    in_valid     <= 1'b1;
    sending = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk); while (pending_retire.size() != 0);
  endtask

  // Receiver back-pressure: each phase is always ready, mostly ready or mostly stalled.
  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  <= 2'($urandom_range(0, 2));
      rx_phase <= $urandom_range(50, 300);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin
    retire_t got;
    retire_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {next_pc, port_id, out_data, read_strobe, write_strobe,
               carry_out, zero_out, int_enable_out, fault};
        if (pending_retire.size() == 0) begin
          report_mismatch("unexpected result, next_pc", got.pc, 0);
        end else begin
          want = pending_retire.pop_front();
          if (got.pc !== want.pc)     report_mismatch("next_pc", got.pc, want.pc);
          if (got.port !== want.port) report_mismatch("port_id", got.port, want.port);
          if (got.data !== want.data) report_mismatch("out_data", got.data, want.data);
          if (got.rd !== want.rd)     report_mismatch("read_strobe", got.rd, want.rd);
          if (got.wr !== want.wr)     report_mismatch("write_strobe", got.wr, want.wr);
          if (got.c !== want.c)       report_mismatch("carry_out", got.c, want.c);
          if (got.z !== want.z)       report_mismatch("zero_out", got.z, want.z);
          if (got.ie !== want.ie)     report_mismatch("int_enable_out", got.ie, want.ie);
          if (got.flt !== want.flt)   report_mismatch("fault", got.flt, want.flt);
        end
        n_checked++;
      end
      if (in_valid && in_ready) begin
        want = execute_instr(instruction, in_port_data);
        if (tag_fixed) begin
          want.pc  = tag_pc;
          want.flt = tag_fault;
        end
        pending_retire.push_back(want);
        n_accepted++;
        if (want.flt == FAULT_OPCODE) n_fault_op++;
        if (want.flt == FAULT_RETURN) n_fault_ret++;
        if (want.rd || want.wr) n_port++;
        if (int'(shadow_depth) > deepest) deepest = int'(shadow_depth);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transfer on either channel for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    vector_t     dir_vec [N_TABLE];
    int          n_random;
    int          n_calls;
    int          next_drain;
    logic        deep_done;
    logic [15:0] ins;

    // Rows with the fixed flag carry a hand-typed next address and fault that override
    // the shadow model's; the rest are left to the shadow model.
    dir_vec = '{
      '{{1'b0, ALU_LOAD, 4'h0, 8'h00},   8'h00, 1'b1, 8'h01, FAULT_NONE},
      '{{1'b0, ALU_LOAD, 4'h1, 8'hFF},   8'hFF, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_ADD, 4'h1, 8'h01},    8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_ADDCY, 4'h0, 8'h00},  8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_SUBCY, 4'h0, 8'h02},  8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_SUB, 4'hF, 8'h00},    8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_OR, 4'hF, 8'hF0},     8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_AND, 4'hF, 8'h0F},    8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{1'b0, ALU_XOR, 4'hE, 8'h5A},    8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_ALU_R, 4'h0, 4'hF, 1'b0, ALU_ADD},   8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_ALU_R, 4'h1, 4'hE, 1'b1, ALU_SUBCY}, 8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_SHIFT, 4'h1, 4'h0, SH_SR1},  8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_SHIFT, 4'h0, 4'hF, SH_SRA},  8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_SHIFT, 4'h2, 4'h0, SH_SL0},  8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_SHIFT, 4'h1, 4'h0, 4'h5},    8'h00, 1'b1, 8'h0F, FAULT_OPCODE},
      '{INS_EINT,                        8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_CTRL, 4'h3, 8'h42},          8'h00, 1'b1, 8'h42, FAULT_NONE},
      '{{OP_CTRL, 4'h0, RET_LOW},        8'h00, 1'b1, 8'h11, FAULT_NONE},
      '{{OP_CTRL, 4'h0, RET_LOW},        8'h00, 1'b1, 8'h00, FAULT_RETURN},
      '{INS_RETI_EN,                     8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_CTRL, 4'h1, 8'hFF},          8'h00, 1'b1, 8'hFF, FAULT_NONE},
      '{{OP_COND, 2'b00, CF_BAD, 8'h00}, 8'h00, 1'b1, 8'h00, FAULT_OPCODE},
      '{{OP_COND, 2'b00, CF_RETURN, 8'h81}, 8'h00, 1'b1, 8'h01, FAULT_OPCODE},
      '{{OP_IN_K, 4'h3, 8'hC5},          8'hA5, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_IN_R, 4'h4, 4'h3, 4'h0},     8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_OUT_K, 4'h3, 8'hFF},         8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_OUT_R, 4'h3, 4'h4, 4'h0},    8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{INS_DINT,                        8'h00, 1'b0, 8'h00, FAULT_NONE},
      '{{OP_CTRL, 12'h000},              8'h00, 1'b0, 8'h00, FAULT_NONE}
    };

    foreach (shadow_reg[i]) shadow_reg[i] = 8'h00;
    foreach (shadow_stack[i]) shadow_stack[i] = 8'h00;
    shadow_pc    = 8'h00;
    shadow_c     = 1'b0;
    shadow_z     = 1'b0;
    shadow_ie    = 1'b0;
    shadow_sp    = 0;
    shadow_depth = 5'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_vec[i]) begin
      issue(dir_vec[i].ins, dir_vec[i].pin, dir_vec[i].fixed, dir_vec[i].pc, dir_vec[i].flt);
    end
    drain();

    n_random   = 0;
    next_drain = DRAIN_EVERY;
    deep_done  = 1'b0;
    while (n_random < N_RANDOM) begin
      if ((!deep_done && n_random >= 100) || $urandom_range(0, 149) == 0) begin
        // Nested calls, the first burst deep enough to wrap the return stack and saturate the
        // call depth and later ones of random depth, then unwound with up to three surplus returns.
        n_calls = deep_done ? $urandom_range(1, 40) : 40;
        deep_done = 1'b1;
        repeat (n_calls) begin
          issue({OP_CTRL, 2'($urandom_range(0, 3)), 2'b11, 8'($urandom_range(0, 255))},
                8'($urandom_range(0, 255)));
          n_random++;
          if ($urandom_range(0, 2) == 0) begin
            issue({1'b0, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095))},
                  8'($urandom_range(0, 255)));
            n_random++;
          end
        end
        repeat (n_calls + $urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) ins = {OP_COND, 2'($urandom_range(0, 3)), CF_RETURN,
                                                RET_LOW};
          else ins = {OP_CTRL, 4'h0, RET_LOW};
          issue(ins, 8'($urandom_range(0, 255)));
          n_random++;
        end
      end else begin
        issue(random_instr(), 8'($urandom_range(0, 255)));
        n_random++;
      end
      if (n_random >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Executed %0d instructions (%0d from the table), %0d results compared, %0d port accesses.",
             n_accepted, N_TABLE, n_checked, n_port);
    $display("Opcode faults %0d, return underflows %0d, deepest call nesting %0d, mismatches %0d.",
             n_fault_op, n_fault_ret, deepest, n_errors);
    if (n_errors == 0 && pending_retire.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
